/* rtl/kcmm_pkg.sv */
package kcmm_pkg;

  // Fixed widths of the channel fields
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATUS_W = 2;

  // Requested operation
  localparam logic ACT_INC = 1'b0;
  localparam logic ACT_DEC = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  // Sequencer commands to the scan unit
  typedef struct packed {
    logic start;   // clear accumulators for a new item
    logic eval;    // slot read data is valid this cycle
    logic action;  // operation of the item in flight
  } scan_cmd_t;

  // Scan unit requests back to the sequencer
  typedef struct packed {
    logic hit_wr;  // write back the matched slot
    logic insert;  // increment of an absent key, and a free slot exists
  } scan_req_t;

endpackage

/* rtl/kcmm_if.sv */
interface kcmm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [kcmm_pkg::KEY_W-1:0]  key;

  modport source (output valid, action, key, input ready);
  modport sink   (input valid, action, key, output ready);
endinterface

interface kcmm_out_if;
  logic                          valid;
  logic                          ready;
  logic [kcmm_pkg::STATUS_W-1:0] status;
  logic                          is_empty;
  logic [kcmm_pkg::KEY_W-1:0]    max_key;
  logic [kcmm_pkg::COUNT_W-1:0]  max_count;
  logic [kcmm_pkg::KEY_W-1:0]    min_key;
  logic [kcmm_pkg::COUNT_W-1:0]  min_count;

  modport source (output valid, status, is_empty, max_key, max_count, min_key, min_count,
                  input ready);
  modport sink   (input valid, status, is_empty, max_key, max_count, min_key, min_count,
                  output ready);
endinterface

/* rtl/kcmm_slot_mem.sv */
module kcmm_slot_mem #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned IDX_W      = $clog2(ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_idx_i,
  output logic                  rd_valid_o,
  output logic [KEY_BITS-1:0]   rd_key_o,
  output logic [COUNT_BITS-1:0] rd_count_o,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_idx_i,
  input  logic                  wr_valid_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic [COUNT_BITS-1:0] wr_count_i
);

  logic [ENTRIES-1:0]    valid_q;
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [ENTRIES];
  logic                  rd_valid_q;
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [COUNT_BITS-1:0] rd_count_q;

  // Slot valid bits: cleared by reset, so an unwritten slot is never used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= wr_valid_i;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_idx_i]   <= wr_key_i;
      count_mem[wr_idx_i] <= wr_count_i;
    end
    if (rd_en_i) begin
      rd_key_q   <= key_mem[rd_idx_i];
      rd_count_q <= count_mem[rd_idx_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_key_o   = rd_key_q;
  assign rd_count_o = rd_count_q;

endmodule

/* rtl/kcmm_scan_unit.sv */
module kcmm_scan_unit #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned IDX_W      = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kcmm_pkg::scan_cmd_t      cmd_i,
  input  logic [KEY_BITS-1:0]      key_i,
  input  logic [IDX_W-1:0]         ev_idx_i,
  input  logic                     ev_valid_i,
  input  logic [KEY_BITS-1:0]      ev_key_i,
  input  logic [COUNT_BITS-1:0]    ev_count_i,
  output kcmm_pkg::scan_req_t      req_o,
  output logic [IDX_W-1:0]         hit_idx_o,
  output logic                     post_valid_o,
  output logic [COUNT_BITS-1:0]    post_count_o,
  output logic [IDX_W-1:0]         free_idx_o,
  output kcmm_pkg::status_e        status_o,
  output logic                     empty_o,
  output logic [KEY_BITS-1:0]      max_key_o,
  output logic [COUNT_BITS-1:0]    max_count_o,
  output logic [KEY_BITS-1:0]      min_key_o,
  output logic [COUNT_BITS-1:0]    min_count_o
);
  import kcmm_pkg::*;

  localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

  logic                  hit_q, free_found_q, any_q;
  status_e               status_q;
  logic [IDX_W-1:0]      free_idx_q, mx_idx_q, mn_idx_q;
  logic [KEY_BITS-1:0]   mx_key_q, mn_key_q;
  logic [COUNT_BITS-1:0] mx_cnt_q, mn_cnt_q;

  logic                  match;
  logic                  post_valid;
  logic [COUNT_BITS-1:0] post_count;
  logic                  sat;

  // Per-slot compare and update: the one unit reused for every slot
  always_comb begin
    match      = cmd_i.eval && ev_valid_i && (ev_key_i == key_i) && !hit_q;
    sat        = (ev_count_i == '1);
    post_valid = ev_valid_i;
    post_count = ev_count_i;
    if (match) begin
      if (cmd_i.action == ACT_INC) begin
        if (!sat) begin
          post_count = ev_count_i + ONE;
        end
      end else if (ev_count_i <= ONE) begin
        post_valid = 1'b0;
        post_count = '0;
      end else begin
        post_count = ev_count_i - ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      any_q        <= 1'b0;
      status_q     <= ST_OK;
    end else if (cmd_i.start) begin
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      any_q        <= 1'b0;
      status_q     <= ST_OK;
    end else if (cmd_i.eval) begin
      if (match) begin
        hit_q    <= 1'b1;
        status_q <= (cmd_i.action == ACT_INC && sat) ? ST_SAT : ST_OK;
      end
      if (!ev_valid_i && !free_found_q) begin
        free_found_q <= 1'b1;
      end
      if (post_valid) begin
        any_q <= 1'b1;
      end
    end
  end

  // Running extremes; strict compares keep the lowest slot on ties
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mx_key_q <= '0;
      mx_cnt_q <= '0;
      mn_key_q <= '0;
      mn_cnt_q <= '0;
      mx_idx_q <= '0;
      mn_idx_q <= '0;
    end else if (cmd_i.eval) begin
      if (!ev_valid_i && !free_found_q) begin
        free_idx_q <= ev_idx_i;
      end
      if (post_valid) begin
        if (!any_q || post_count > mx_cnt_q) begin
          mx_key_q <= ev_key_i;
          mx_cnt_q <= post_count;
          mx_idx_q <= ev_idx_i;
        end
        if (!any_q || post_count < mn_cnt_q) begin
          mn_key_q <= ev_key_i;
          mn_cnt_q <= post_count;
          mn_idx_q <= ev_idx_i;
        end
      end
    end
  end

  assign req_o.hit_wr = match;
  assign req_o.insert = (cmd_i.action == ACT_INC) && !hit_q && free_found_q;
  assign hit_idx_o    = ev_idx_i;
  assign post_valid_o = post_valid;
  assign post_count_o = post_count;
  assign free_idx_o   = free_idx_q;

  // Fold a new key (count one, at the free slot) into the extremes
  always_comb begin
    max_key_o   = mx_key_q;
    max_count_o = mx_cnt_q;
    min_key_o   = mn_key_q;
    min_count_o = mn_cnt_q;
    if (req_o.insert) begin
      if (!any_q || (mx_cnt_q == ONE && free_idx_q < mx_idx_q)) begin
        max_key_o   = key_i;
        max_count_o = ONE;
      end
      if (!any_q || mn_cnt_q > ONE || (mn_cnt_q == ONE && free_idx_q < mn_idx_q)) begin
        min_key_o   = key_i;
        min_count_o = ONE;
      end
    end
  end

  always_comb begin
    if (hit_q) begin
      status_o = status_q;
    end else if (cmd_i.action == ACT_DEC) begin
      status_o = ST_ABSENT;
    end else if (free_found_q) begin
      status_o = ST_OK;
    end else begin
      status_o = ST_FULL;
    end
  end

  assign empty_o = !(any_q || req_o.insert);

endmodule

/* rtl/key_count_min_max_table_core.sv */
// Key count table with largest and smallest count report.
//
// in_i carries one item per operation: action (increment or decrement) and
// a key tag. out_o returns exactly one result item per input item: status,
// an empty flag, and one key with the largest count and one with the
// smallest count (lowest slot on ties), both taken after the operation.
//
// Each item runs one pass of a shared compare/update unit over the slot
// memory, one slot per cycle: the pass finds the key, the lowest free slot
// and the extremes together. in_i.ready is high only while the sequencer
// is idle, so a new item is taken only once the previous item's pass has
// closed; the pass length is set by the one-read-per-cycle slot memory port.
//
// A result waits in the output register while out_o.ready is low; the next
// item is still taken, but its pass holds at the end until the register is
// free. Reset empties the table at once (valid bits are flip-flops) and
// drops any pending result; no clearing pass is needed.
module key_count_min_max_table_core #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kcmm_in_if.sink     in_i,
  kcmm_out_if.source  out_o
);
  import kcmm_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned KW    = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
  localparam int unsigned CW    = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  ev_pend_q;
  logic [IDX_W-1:0]      ev_idx_q;
  logic                  action_q;
  logic [KEY_BITS-1:0]   key_q;

  logic                  in_acc;
  logic                  rd_en;
  logic                  rd_last;
  logic                  finish;
  logic [KW-1:0]         key_in_wide;

  scan_cmd_t             cmd;
  scan_req_t             req;

  logic                  mem_valid;
  logic [KEY_BITS-1:0]   mem_key;
  logic [COUNT_BITS-1:0] mem_count;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic                  wr_valid;
  logic [COUNT_BITS-1:0] wr_count;

  logic [IDX_W-1:0]      hit_idx;
  logic                  post_valid;
  logic [COUNT_BITS-1:0] post_count;
  logic [IDX_W-1:0]      free_idx;
  status_e               status;
  logic                  empty;
  logic [KEY_BITS-1:0]   max_key, min_key;
  logic [COUNT_BITS-1:0] max_count, min_count;
  logic [KW-1:0]         max_key_wide, min_key_wide;
  logic [CW-1:0]         max_cnt_wide, min_cnt_wide;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic                  out_empty_q;
  logic [KEY_W-1:0]      out_max_key_q, out_min_key_q;
  logic [COUNT_W-1:0]    out_max_cnt_q, out_min_cnt_q;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign key_in_wide = KW'(in_i.key);

  assign rd_en   = (state_q == S_SCAN);
  assign rd_last = (rd_idx_q == IDX_W'(ENTRIES - 1));
  // Close the item once the last slot is evaluated and the output is free
  assign finish  = (state_q == S_FIN) && !ev_pend_q && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_idx_q  <= '0;
      ev_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ev_pend_q <= rd_en;
      if (in_acc) begin
        rd_idx_q <= '0;
      end else if (rd_en && !rd_last) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
    end
  end

  // Hold the operation and track the slot whose read data is arriving
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      action_q <= in_i.action;
      key_q    <= key_in_wide[KEY_BITS-1:0];
    end
    if (rd_en) begin
      ev_idx_q <= rd_idx_q;
    end
  end

  assign cmd.start  = in_acc;
  assign cmd.eval   = ev_pend_q;
  assign cmd.action = action_q;

  kcmm_slot_mem #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_idx_q),
    .rd_valid_o (mem_valid),
    .rd_key_o   (mem_key),
    .rd_count_o (mem_count),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_valid_i (wr_valid),
    .wr_key_i   (key_q),
    .wr_count_i (wr_count)
  );

  kcmm_scan_unit #(
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .key_i        (key_q),
    .ev_idx_i     (ev_idx_q),
    .ev_valid_i   (mem_valid),
    .ev_key_i     (mem_key),
    .ev_count_i   (mem_count),
    .req_o        (req),
    .hit_idx_o    (hit_idx),
    .post_valid_o (post_valid),
    .post_count_o (post_count),
    .free_idx_o   (free_idx),
    .status_o     (status),
    .empty_o      (empty),
    .max_key_o    (max_key),
    .max_count_o  (max_count),
    .min_key_o    (min_key),
    .min_count_o  (min_count)
  );

  // One write port: matched slot during the pass, new key when closing.
  // The two never coincide, since closing waits for the last evaluation.
  always_comb begin
    if (finish && req.insert) begin
      wr_en    = 1'b1;
      wr_idx   = free_idx;
      wr_valid = 1'b1;
      wr_count = COUNT_BITS'(1);
    end else begin
      wr_en    = req.hit_wr;
      wr_idx   = hit_idx;
      wr_valid = post_valid;
      wr_count = post_count;
    end
  end

  assign max_key_wide = KW'(max_key);
  assign min_key_wide = KW'(min_key);
  assign max_cnt_wide = CW'(max_count);
  assign min_cnt_wide = CW'(min_count);

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_status_q  <= status;
      out_empty_q   <= empty;
      out_max_key_q <= max_key_wide[KEY_W-1:0];
      out_min_key_q <= min_key_wide[KEY_W-1:0];
      out_max_cnt_q <= max_cnt_wide[COUNT_W-1:0];
      out_min_cnt_q <= min_cnt_wide[COUNT_W-1:0];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.is_empty  = out_empty_q;
  assign out_o.max_key   = out_max_key_q;
  assign out_o.max_count = out_max_cnt_q;
  assign out_o.min_key   = out_min_key_q;
  assign out_o.min_count = out_min_cnt_q;

endmodule

/* rtl/kcmm_checker.sv */
module kcmm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [kcmm_pkg::STATUS_W-1:0] status_i,
  input logic                          is_empty_i,
  input logic [kcmm_pkg::COUNT_W-1:0]  max_count_i,
  input logic [kcmm_pkg::COUNT_W-1:0]  min_count_i
);
  import kcmm_pkg::*;

  // Input not ready straight after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken again right after an accept");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && is_empty_i) |-> (max_count_i == '0 && min_count_i == '0))
    else $error("empty table reports a nonzero count");

  a_extremes_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !is_empty_i) |-> (max_count_i >= min_count_i && min_count_i != '0))
    else $error("largest and smallest counts out of order");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == ST_FULL) |-> !is_empty_i)
    else $error("full status on an empty table");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before it was taken");

endmodule

bind key_count_min_max_table_core kcmm_checker u_kcmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .is_empty_i  (out_o.is_empty),
  .max_count_i (out_o.max_count),
  .min_count_i (out_o.min_count)
);
